// ----- rtl/gqtl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqtl_pkg
// Shared types and constants for the glyph quad text layout block.
// ----------------------------------------------------------------------------
package gqtl_pkg;

	// atlas height in texels, v coordinates are flipped from it
	localparam int unsigned ATLAS_H = 512;

	localparam int unsigned PADDR_W = 5;

	localparam logic [7:0]  CHAR_NEWLINE = 8'd10;
	localparam logic [13:0] X_MAX        = 14'h3FFF;

	typedef enum logic [2:0] {
		REG_ORIGIN_X       = 3'd0,
		REG_ORIGIN_Y       = 3'd1,
		REG_BOX_W          = 3'd2,
		REG_BOX_H          = 3'd3,
		REG_GLYPH_W        = 3'd4,
		REG_GLYPH_H        = 3'd5,
		REG_FONT_SCALE     = 3'd6,
		REG_GLYPHS_PER_ROW = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0] origin_x;
		logic [11:0] origin_y;
		logic [12:0] box_w;
		logic [12:0] box_h;
		logic [6:0]  glyph_w;
		logic [6:0]  glyph_h;
		logic [3:0]  font_scale;
		logic [8:0]  glyphs_per_row;
	} cfg_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic       done;
		logic [7:0] quot;
		logic [7:0] rem;
	} div_res_t;

endpackage

// ----- rtl/gqtl_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqtl_in_if
// Character channel: one character code per transaction.
// ----------------------------------------------------------------------------
interface gqtl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       first;

	modport source(output valid, output char_code, output first, input ready);
	modport sink(input valid, input char_code, input first, output ready);
endinterface

// ----- rtl/gqtl_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqtl_out_if
// Quad channel: screen and atlas corners of one glyph per transaction.
// ----------------------------------------------------------------------------
interface gqtl_out_if;
	logic               valid;
	logic               ready;
	logic [13:0]        x_left;
	logic [13:0]        x_right;
	logic signed [14:0] y_bottom;
	logic signed [14:0] y_top;
	logic [13:0]        u_left;
	logic [13:0]        u_right;
	logic signed [15:0] v_top;
	logic signed [15:0] v_bottom;
	logic [15:0]        quad_index;

	modport source(output valid, output x_left, output x_right, output y_bottom,
		output y_top, output u_left, output u_right, output v_top, output v_bottom,
		output quad_index, input ready);
	modport sink(input valid, input x_left, input x_right, input y_bottom,
		input y_top, input u_left, input u_right, input v_top, input v_bottom,
		input quad_index, output ready);
endinterface

// ----- rtl/gqtl_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqtl_regs
// APB configuration registers, one 32-bit word per register.
// ----------------------------------------------------------------------------
module gqtl_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gqtl_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output gqtl_pkg::cfg_t               cfg
);
	import gqtl_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x       <= 12'd0;
			cfg_q.origin_y       <= 12'd0;
			cfg_q.box_w          <= 13'd256;
			cfg_q.box_h          <= 13'd64;
			cfg_q.glyph_w        <= 7'd8;
			cfg_q.glyph_h        <= 7'd16;
			cfg_q.font_scale     <= 4'd1;
			cfg_q.glyphs_per_row <= 9'd16;
		end else if (wr_en) begin
			case (idx)
				REG_ORIGIN_X:       cfg_q.origin_x       <= pwdata[11:0];
				REG_ORIGIN_Y:       cfg_q.origin_y       <= pwdata[11:0];
				REG_BOX_W:          cfg_q.box_w          <= pwdata[12:0];
				REG_BOX_H:          cfg_q.box_h          <= pwdata[12:0];
				REG_GLYPH_W:        cfg_q.glyph_w        <= pwdata[6:0];
				REG_GLYPH_H:        cfg_q.glyph_h        <= pwdata[6:0];
				REG_FONT_SCALE:     cfg_q.font_scale     <= pwdata[3:0];
				REG_GLYPHS_PER_ROW: cfg_q.glyphs_per_row <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ORIGIN_X:       prdata = {20'd0, cfg_q.origin_x};
			REG_ORIGIN_Y:       prdata = {20'd0, cfg_q.origin_y};
			REG_BOX_W:          prdata = {19'd0, cfg_q.box_w};
			REG_BOX_H:          prdata = {19'd0, cfg_q.box_h};
			REG_GLYPH_W:        prdata = {25'd0, cfg_q.glyph_w};
			REG_GLYPH_H:        prdata = {25'd0, cfg_q.glyph_h};
			REG_FONT_SCALE:     prdata = {28'd0, cfg_q.font_scale};
			REG_GLYPHS_PER_ROW: prdata = {23'd0, cfg_q.glyphs_per_row};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

// ----- rtl/gqtl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqtl_div
// Restoring divider, 8-bit code by glyphs per row, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gqtl_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [7:0]           dividend,
	input  logic [8:0]           divisor,
	output gqtl_pkg::div_res_t   res
);
	import gqtl_pkg::*;

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] quot_q;
	logic [8:0] rem_q;
	logic [8:0] div_q;
	logic [8:0] trial;
	logic       fits;

	// remainder stays below the divisor, which is at most 511
	assign trial = {rem_q[7:0], quot_q[7]};
	assign fits  = trial >= div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
			quot_q <= 8'd0;
			rem_q  <= 9'd0;
			div_q  <= 9'd1;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
			quot_q <= dividend;
			rem_q  <= 9'd0;
			// zero glyphs per row acts as one
			div_q  <= (divisor == 9'd0) ? 9'd1 : divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? (trial - div_q) : trial;
			quot_q <= {quot_q[6:0], fits};
			cnt_q  <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q[7:0];

endmodule

// ----- rtl/gqtl_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqtl_core
// Layout sequencer: shared multiplier for glyph sizes and atlas offsets,
// cursor state, wrap and full tests, and the output register.
// ----------------------------------------------------------------------------
module gqtl_core #(
	parameter int unsigned ATLAS_H = gqtl_pkg::ATLAS_H
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gqtl_pkg::cfg_t       cfg,
	gqtl_in_if.sink              chars,
	gqtl_out_if.source           quads,
	output logic                 div_start,
	output logic [7:0]           div_dividend,
	output logic [8:0]           div_divisor,
	input  gqtl_pkg::div_res_t   div_res
);
	import gqtl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_SW,
		S_MUL_SH,
		S_START,
		S_DIV,
		S_MUL_U,
		S_MUL_V,
		S_ADD,
		S_FIN
	} state_t;

	localparam logic [16:0] ATLAS_V = 17'(ATLAS_H);

	state_t             state_q;
	logic [7:0]         code_q;
	logic               first_q;
	logic [10:0]        sw_q;
	logic [10:0]        sh_q;
	logic [14:0]        u0_q;
	logic [14:0]        rh_q;

	logic [13:0]        cursor_x_q;
	logic signed [14:0] cursor_y_q;
	logic               full_q;
	logic [15:0]        qcount_q;

	logic               emit_q;
	logic [14:0]        cx1_q;
	logic [13:0]        xr_q;
	logic signed [14:0] yt_q;
	logic [13:0]        ul_q;
	logic [13:0]        ur_q;
	logic signed [15:0] vt_q;
	logic signed [15:0] vb_q;

	logic               out_valid_q;
	logic [13:0]        o_xl_q, o_xr_q, o_ul_q, o_ur_q;
	logic signed [14:0] o_yb_q, o_yt_q;
	logic signed [15:0] o_vt_q, o_vb_q;
	logic [15:0]        o_idx_q;

	// shared multiplier
	logic [7:0]         mul_a;
	logic [6:0]         mul_b;
	logic [14:0]        mul_p;

	// add stage
	logic               emit;
	logic [14:0]        xr_sum;
	logic signed [15:0] cy16;
	logic signed [15:0] yt_sum;
	logic [15:0]        ur_sum;
	logic signed [16:0] vt17;
	logic signed [16:0] vb17;
	logic signed [15:0] y_start;

	// finish stage
	logic [15:0]        wrap_lhs;
	logic [15:0]        wrap_rhs;
	logic               wrap;
	logic signed [15:0] cy_wrap;
	logic               out_free;
	logic               fin_go;

	assign chars.ready  = (state_q == S_IDLE);
	assign div_start    = chars.valid && chars.ready;
	assign div_dividend = chars.char_code;
	assign div_divisor  = cfg.glyphs_per_row;

	always_comb begin
		case (state_q)
			S_MUL_SW: begin
				mul_a = {4'd0, cfg.font_scale};
				mul_b = cfg.glyph_w;
			end
			S_MUL_SH: begin
				mul_a = {4'd0, cfg.font_scale};
				mul_b = cfg.glyph_h;
			end
			S_MUL_U: begin
				mul_a = div_res.rem;
				mul_b = cfg.glyph_w;
			end
			S_MUL_V: begin
				mul_a = div_res.quot;
				mul_b = cfg.glyph_h;
			end
			default: begin
				mul_a = 8'd0;
				mul_b = 7'd0;
			end
		endcase
	end

	assign mul_p = {7'd0, mul_a} * {8'd0, mul_b};

	assign emit    = !full_q && (code_q != CHAR_NEWLINE);
	assign xr_sum  = {1'b0, cursor_x_q} + {4'd0, sw_q};
	assign cy16    = {cursor_y_q[14], cursor_y_q};
	assign yt_sum  = cy16 + $signed({5'd0, sh_q});
	assign ur_sum  = {1'b0, u0_q} + {9'd0, cfg.glyph_w};
	assign vt17    = $signed(ATLAS_V) - $signed({2'd0, rh_q});
	assign vb17    = vt17 - $signed({10'd0, cfg.glyph_h});
	// box top minus one line never leaves the 15-bit range
	assign y_start = $signed({4'd0, cfg.origin_y}) + $signed({3'd0, cfg.box_h})
		- $signed({5'd0, sh_q});

	assign wrap_lhs = {1'b0, cx1_q} + {9'd0, cfg.glyph_w};
	assign wrap_rhs = {4'd0, cfg.origin_x} + {3'd0, cfg.box_w};
	assign wrap     = (code_q == CHAR_NEWLINE) || (wrap_lhs >= wrap_rhs);
	assign cy_wrap  = cy16 - $signed({5'd0, sh_q});
	assign out_free = !out_valid_q || quads.ready;
	assign fin_go   = !emit_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= 8'd0;
			first_q     <= 1'b0;
			sw_q        <= 11'd0;
			sh_q        <= 11'd0;
			u0_q        <= 15'd0;
			rh_q        <= 15'd0;
			cursor_x_q  <= 14'd0;
			cursor_y_q  <= 15'sd0;
			full_q      <= 1'b0;
			qcount_q    <= 16'd0;
			emit_q      <= 1'b0;
			cx1_q       <= 15'd0;
			xr_q        <= 14'd0;
			yt_q        <= 15'sd0;
			ul_q        <= 14'd0;
			ur_q        <= 14'd0;
			vt_q        <= 16'sd0;
			vb_q        <= 16'sd0;
			out_valid_q <= 1'b0;
			o_xl_q      <= 14'd0;
			o_xr_q      <= 14'd0;
			o_yb_q      <= 15'sd0;
			o_yt_q      <= 15'sd0;
			o_ul_q      <= 14'd0;
			o_ur_q      <= 14'd0;
			o_vt_q      <= 16'sd0;
			o_vb_q      <= 16'sd0;
			o_idx_q     <= 16'd0;
		end else begin
			// a quad loaded in the finish step takes the place of one leaving
			if (quads.valid && quads.ready && !(state_q == S_FIN && fin_go && emit_q)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (chars.valid) begin
						code_q  <= chars.char_code;
						first_q <= chars.first;
						state_q <= S_MUL_SW;
					end
				end
				S_MUL_SW: begin
					sw_q    <= mul_p[10:0];
					state_q <= S_MUL_SH;
				end
				S_MUL_SH: begin
					sh_q    <= mul_p[10:0];
					state_q <= S_START;
				end
				S_START: begin
					if (first_q) begin
						cursor_x_q <= {2'd0, cfg.origin_x};
						cursor_y_q <= y_start[14:0];
						full_q     <= 1'b0;
						qcount_q   <= 16'd0;
					end
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_MUL_U;
					end
				end
				S_MUL_U: begin
					u0_q    <= mul_p;
					state_q <= S_MUL_V;
				end
				S_MUL_V: begin
					rh_q    <= mul_p;
					state_q <= S_ADD;
				end
				S_ADD: begin
					emit_q  <= emit;
					cx1_q   <= emit ? xr_sum : {1'b0, cursor_x_q};
					xr_q    <= xr_sum[14] ? X_MAX : xr_sum[13:0];
					yt_q    <= (!yt_sum[15] && yt_sum[14]) ? 15'sh3FFF : yt_sum[14:0];
					ul_q    <= u0_q[14] ? X_MAX : u0_q[13:0];
					ur_q    <= (ur_sum[15:14] != 2'd0) ? X_MAX : ur_sum[13:0];
					vt_q    <= vt17[15:0];
					vb_q    <= vb17[15:0];
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						if (emit_q) begin
							out_valid_q <= 1'b1;
							o_xl_q      <= cursor_x_q;
							o_xr_q      <= xr_q;
							o_yb_q      <= cursor_y_q;
							o_yt_q      <= yt_q;
							o_ul_q      <= ul_q;
							o_ur_q      <= ur_q;
							o_vt_q      <= vt_q;
							o_vb_q      <= vb_q;
							o_idx_q     <= qcount_q;
							if (qcount_q != 16'hFFFF) begin
								qcount_q <= qcount_q + 16'd1;
							end
						end
						// a full text keeps its cursor as it is
						if (!full_q) begin
							if (wrap) begin
								cursor_x_q <= {2'd0, cfg.origin_x};
								cursor_y_q <= (cy_wrap < -16'sd16384) ? -15'sd16384
									: cy_wrap[14:0];
								if (cy_wrap < $signed({4'd0, cfg.origin_y})) begin
									full_q <= 1'b1;
								end
							end else begin
								cursor_x_q <= cx1_q[14] ? X_MAX : cx1_q[13:0];
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign quads.valid      = out_valid_q;
	assign quads.x_left     = o_xl_q;
	assign quads.x_right    = o_xr_q;
	assign quads.y_bottom   = o_yb_q;
	assign quads.y_top      = o_yt_q;
	assign quads.u_left     = o_ul_q;
	assign quads.u_right    = o_ur_q;
	assign quads.v_top      = o_vt_q;
	assign quads.v_bottom   = o_vb_q;
	assign quads.quad_index = o_idx_q;

endmodule

// ----- rtl/glyph_quad_text_layout.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_quad_text_layout
// Lays a stream of character codes out as glyph quads in a text box.
//
//   channel   dir   kind        transaction
//   chars     in    valid/rdy   char_code, first
//   quads     out   valid/rdy   screen and atlas corners, quad_index
//   apb       in    APB write   8 registers at byte address 4*i
//
// One character at a time: chars.ready is low after a transaction until the
// finish step is through (8-step divider under the scale products and start
// step, wait for done, two atlas products, add, finish). Newlines and dropped
// characters give no quad. A quad waits in the output register; the next
// character is taken meanwhile but stalls in its finish step until it has gone.
// Reset is asynchronous, active low; no memory, no clearing pass.
// ----------------------------------------------------------------------------
module glyph_quad_text_layout #(
	parameter int unsigned ATLAS_H = gqtl_pkg::ATLAS_H
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gqtl_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	gqtl_in_if.sink                      chars,
	gqtl_out_if.source                   quads
);
	import gqtl_pkg::*;

	cfg_t     cfg;
	div_res_t div_res;
	logic     div_start;
	logic [7:0] div_dividend;
	logic [8:0] div_divisor;

	gqtl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gqtl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.res      (div_res)
	);

	gqtl_core #(
		.ATLAS_H (ATLAS_H)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.chars        (chars),
		.quads        (quads),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_res      (div_res)
	);

`ifndef SYNTHESIS
	// the block is busy for the cycle after it takes a character
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && chars.ready |=> !chars.ready)
		else $error("chars.ready high right after a transaction");

	// a new quad only comes from a character in progress
	a_quad_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(quads.valid) |-> $past(!chars.ready))
		else $error("quad appeared while idle");

	// starting the divider clears its done flag
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_res.done)
		else $error("divider done flag not cleared on start");
`endif

endmodule
